/* hdl/ed_pkg.sv */
// ed_pkg: shared constants and types for the edit distance engine
// used by ed_cell and edit_distance; no dependencies

package ed_pkg;

  localparam int MAX_LEN = 256;
  localparam int CP_W    = 21;
  localparam int CMD_W   = 2;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int CNT_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PROCESS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH  = 2'd2;

  // one dp column update travelling down the chain
  typedef struct packed {
    logic             valid;
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] diag;
    logic [LEN_W-1:0] up;
  } wave_t;

  // stored symbol and column entry of one cell
  typedef struct packed {
    logic             act;
    logic [CP_W-1:0]  ch;
    logic [LEN_W-1:0] value;
  } slot_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic load;
    logic clear;
  } ctl_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

endpackage

/* hdl/ed_cell.sv */
// ed_cell: one systolic cell holding a first-string symbol and its column entry
// depends on ed_pkg

module ed_cell
  import ed_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  ctl_t  ctl,
  input  slot_t slot_in,
  output slot_t slot,
  input  wave_t wave_in,
  output wave_t wave_out
);

  logic [LEN_W-1:0] m1;
  logic [LEN_W-1:0] m2;
  logic [LEN_W-1:0] cost;

  always_comb begin
    m1 = (slot.value < wave_in.up) ? slot.value : wave_in.up;
    m2 = (m1 < wave_in.diag) ? m1 : wave_in.diag;
    if (slot.ch == wave_in.cp) begin
      cost = wave_in.diag;
    end else begin
      cost = m2 + LEN_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.act       <= 1'b0;
      wave_out.valid <= 1'b0;
    end else begin
      wave_out.valid <= wave_in.valid;
      if (ctl.clear) begin
        slot.act <= 1'b0;
      end else if (ctl.load) begin
        slot.act <= slot_in.act;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    wave_out.cp <= wave_in.cp;
    if (ctl.load) begin
      slot.ch    <= slot_in.ch;
      slot.value <= slot_in.value;
    end else if (wave_in.valid && slot.act) begin
      slot.value <= cost;
    end
    if (slot.act) begin
      wave_out.diag <= slot.value;
      wave_out.up   <= cost;
    end else begin
      wave_out.diag <= wave_in.diag;
      wave_out.up   <= wave_in.up;
    end
  end

endmodule

/* hdl/edit_distance.sv */
// edit_distance: levenshtein distance engine built as a chain of ed_cell
// depends on ed_pkg and ed_cell
//
// usage: drive command and code_point with start; a transfer happens at a
// clock edge where start is high and busy is low. command 0 loads the next
// first-string code point, command 1 streams one second-string code point,
// command 2 finishes and reports the distance.
// the first string sits right-aligned in a chain of MAX_LEN cells; each load
// shifts the chain by one. each second-string point enters cell 0 as a wave
// and moves one cell per cycle, so loads and processes transfer one per
// cycle and busy stays low for them.
// finish raises busy until the last wave has left the chain. the result
// then shows on distance and overflow for exactly one cycle with done
// high; the receiver cannot stall, and busy drops in the same cycle. the
// engine is then cleared for the next pair.
// reset clears the lengths, the overflow flag and all cell flags; no result
// is pending after reset.

module edit_distance
  import ed_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [CMD_W-1:0] command,
  input  logic [CP_W-1:0]  code_point,
  output logic             done,
  output logic [LEN_W-1:0] distance,
  output logic             overflow
);

  state_t           state;
  logic [LEN_W-1:0] first_length;
  logic [LEN_W-1:0] second_count;
  logic             overflow_seen;
  logic [CNT_W-1:0] drain;

  logic             accept;
  logic             load_req;
  logic             proc_req;
  logic             load_ok;
  logic             proc_ok;
  logic             finish_now;
  ctl_t             ctl;
  wave_t            wave0;
  slot_t            slot_tail;

  wave_t            waves [MAX_LEN+1];
  slot_t            slots [MAX_LEN+1];

  assign busy   = (state == S_DRAIN);
  assign accept = start && !busy;

  assign load_req = accept && (command == CMD_LOAD) && !overflow_seen
                    && (second_count == '0);
  assign proc_req = accept && (command == CMD_PROCESS) && !overflow_seen;
  assign load_ok  = load_req && (first_length != LEN_W'(MAX_LEN));
  assign proc_ok  = proc_req && (second_count != LEN_W'(MAX_LEN));

  assign finish_now = (state == S_DRAIN) && (drain == '0);

  assign ctl.load  = load_ok;
  assign ctl.clear = finish_now;

  always_comb begin
    wave0.valid = proc_ok;
    wave0.cp    = code_point;
    wave0.diag  = second_count;
    wave0.up    = second_count + LEN_W'(1);
  end

  always_comb begin
    slot_tail.act   = 1'b1;
    slot_tail.ch    = code_point;
    slot_tail.value = first_length + LEN_W'(1);
  end

  assign waves[0]       = wave0;
  assign slots[MAX_LEN] = slot_tail;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    ed_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .slot_in  (slots[k+1]),
      .slot     (slots[k]),
      .wave_in  (waves[k]),
      .wave_out (waves[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_length  <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
      drain         <= '0;
      done          <= 1'b0;
    end else begin
      done <= finish_now;
      if (proc_ok) begin
        drain <= CNT_W'(MAX_LEN - 1);
      end else if (drain != '0) begin
        drain <= drain - CNT_W'(1);
      end
      if (load_ok) begin
        first_length <= first_length + LEN_W'(1);
      end
      if (proc_ok) begin
        second_count <= second_count + LEN_W'(1);
      end
      if ((load_req && !load_ok) || (proc_req && !proc_ok)) begin
        overflow_seen <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept && (command == CMD_FINISH)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (finish_now) begin
            first_length  <= '0;
            second_count  <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (finish_now) begin
      overflow <= overflow_seen;
      if (overflow_seen) begin
        distance <= '0;
      end else if (first_length == '0) begin
        distance <= second_count;
      end else begin
        distance <= slots[MAX_LEN-1].value;
      end
    end
  end

  // a result leaves only after the drain state
  a_done_after_drain : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DRAIN))
    else $error("result without finish drain");

  a_overflow_zero : assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |-> (distance == '0))
    else $error("nonzero distance on overflow");

  a_drain_reload : assert property (@(posedge clk) disable iff (rst)
    proc_ok |=> (drain == CNT_W'(MAX_LEN - 1)))
    else $error("drain counter not reloaded by process transfer");

  a_no_wave_on_finish : assert property (@(posedge clk) disable iff (rst)
    finish_now |-> !waves[MAX_LEN-1].valid)
    else $error("finish taken while a wave is still in the chain");

endmodule
